// ===== rtl/tpls_pkg.sv =====
// Shared types, constants and helpers for the thermal printhead line sequencer.
// No dependencies; every other file of the block imports this package.
package tpls_pkg;

  localparam int LINE_BYTES_MAX = 64;
  localparam logic [6:0] LINE_BYTES_RESET = 7'd48;
  localparam logic [6:0] LINE_BYTES_CAP = 7'(LINE_BYTES_MAX);

  typedef enum logic [2:0] {
    ACT_ENABLE  = 3'd0,
    ACT_SHIFT   = 3'd1,
    ACT_LATCH   = 3'd2,
    ACT_STROBE  = 3'd3,
    ACT_STEP    = 3'd4,
    ACT_DISABLE = 3'd5
  } action_t;

  // One classified byte waiting for the back end.
  typedef struct packed {
    logic [7:0] dots;
    logic       first;   // byte opens a line
    logic       closing; // byte ends a line
    logic [1:0] phase;   // motor phase at the first step of this line end
  } line_entry_t;

  localparam logic [1:0] LAST_STROBE_GROUP = 2'd2;

  function automatic logic [3:0] coil_for(input logic [1:0] phase);
    logic [3:0] coil;
    case (phase)
      2'd0:    coil = 4'h5;
      2'd1:    coil = 4'h6;
      2'd2:    coil = 4'hA;
      default: coil = 4'h9;
    endcase
    return coil;
  endfunction

endpackage

// ===== rtl/tpls_front.sv =====
// Front end: accepts dot bytes and classifies them as first or last of a line.
// Depends on tpls_pkg.
module tpls_front import tpls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [6:0]  line_bytes,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  dot_byte,
  input  logic        q_full,
  output logic        push,
  output line_entry_t push_entry
);

  logic [5:0] byte_position;
  logic [1:0] motor_phase;
  logic [6:0] len_eff;
  logic       closing;

  always_comb begin
    if (line_bytes == 7'd0) begin
      len_eff = 7'd1;
    end else if (line_bytes > LINE_BYTES_CAP) begin
      len_eff = LINE_BYTES_CAP;
    end else begin
      len_eff = line_bytes;
    end
  end

  assign closing  = ({1'b0, byte_position} + 7'd1) >= len_eff;
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign push_entry.dots    = dot_byte;
  assign push_entry.first   = (byte_position == 6'd0);
  assign push_entry.closing = closing;
  assign push_entry.phase   = motor_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 6'd0;
      motor_phase   <= 2'd0;
    end else if (push) begin
      if (closing) begin
        byte_position <= 6'd0;
        motor_phase   <= motor_phase + 2'd2;
      end else begin
        byte_position <= byte_position + 6'd1;
      end
    end
  end

endmodule

// ===== rtl/tpls_queue.sv =====
// Two-entry queue of classified bytes between front and back end.
// Depends on tpls_pkg.
module tpls_queue import tpls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  line_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output logic        head_valid,
  output line_entry_t head
);

  line_entry_t slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/tpls_back.sv =====
// Back end: expands the queue head into pin actions, one per cycle unless stalled.
// Depends on tpls_pkg.
module tpls_back import tpls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  line_entry_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic        data_bit,
  output logic [1:0]  strobe_group,
  output logic [3:0]  coil_pattern,
  output logic        last_action
);

  typedef enum logic [6:0] {
    ST_START   = 7'b0000001,
    ST_ENABLE  = 7'b0000010,
    ST_SHIFT   = 7'b0000100,
    ST_LATCH   = 7'b0001000,
    ST_STROBE  = 7'b0010000,
    ST_STEP    = 7'b0100000,
    ST_DISABLE = 7'b1000000
  } seq_state_t;

  seq_state_t state, state_next, cur;
  logic [2:0] cnt, cnt_next;
  logic       emit;
  logic       done;
  action_t    act;

  assign emit = head_valid && (!out_valid || out_ready);

  // A fresh item starts either with the enable action or straight in the shifts.
  always_comb begin
    if (state == ST_START) begin
      cur = head.first ? ST_ENABLE : ST_SHIFT;
    end else begin
      cur = state;
    end
  end

  always_comb begin
    state_next = cur;
    cnt_next   = cnt;
    done       = 1'b0;
    act        = ACT_ENABLE;
    case (cur)
      ST_ENABLE: begin
        act        = ACT_ENABLE;
        state_next = ST_SHIFT;
        cnt_next   = 3'd0;
      end
      ST_SHIFT: begin
        act = ACT_SHIFT;
        if (cnt == 3'd7) begin
          cnt_next = 3'd0;
          if (head.closing) begin
            state_next = ST_LATCH;
          end else begin
            state_next = ST_START;
            done       = 1'b1;
          end
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_LATCH: begin
        act        = ACT_LATCH;
        state_next = ST_STROBE;
        cnt_next   = 3'd0;
      end
      ST_STROBE: begin
        act = ACT_STROBE;
        if (cnt[1:0] == LAST_STROBE_GROUP) begin
          state_next = ST_STEP;
          cnt_next   = 3'd0;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_STEP: begin
        act = ACT_STEP;
        if (cnt[0]) begin
          state_next = ST_DISABLE;
          cnt_next   = 3'd0;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_DISABLE: begin
        act        = ACT_DISABLE;
        state_next = ST_START;
        cnt_next   = 3'd0;
        done       = 1'b1;
      end
      default: begin
        state_next = ST_START;
        cnt_next   = 3'd0;
      end
    endcase
  end

  assign pop = emit && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_START;
      cnt       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        state     <= state_next;
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      action       <= act;
      data_bit     <= (act == ACT_SHIFT) ? head.dots[3'd7 - cnt] : 1'b0;
      strobe_group <= (act == ACT_STROBE) ? cnt[1:0] : 2'd0;
      coil_pattern <= (act == ACT_STEP) ? coil_for(head.phase + {1'b0, cnt[0]}) : 4'h0;
      last_action  <= done;
    end
  end

endmodule

// ===== rtl/thermal_printhead_line_sequencer.sv =====
// Top level of the thermal printhead line sequencer: config register and the
// front end, queue and back end. Depends on tpls_pkg, tpls_front, tpls_queue, tpls_back.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    dot_byte
//   out       output     out_valid / out_ready  action, data_bit, strobe_group,
//                                               coil_pattern, last_action
//   cfg       input      cfg_write              cfg_data (line_bytes)
//
// The back end issues one action item per cycle from its output register unless
// out_ready stalls it. A byte expands to 8 items in mid-line, 9 when it opens a
// line and 7 more when it closes one; that single sequencer sets the sustained rate.
// Reset (rst, synchronous) empties the queue, clears line position and motor
// phase, and loads line_bytes with 48. A stalled output holds its item; the
// two-entry queue keeps taking bytes until it is full.
module thermal_printhead_line_sequencer import tpls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] dot_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] action,
  output logic       data_bit,
  output logic [1:0] strobe_group,
  output logic [3:0] coil_pattern,
  output logic       last_action
);

  logic [6:0]  line_bytes;
  logic        push;
  line_entry_t push_entry;
  logic        q_full;
  logic        pop;
  logic        head_valid;
  line_entry_t head;

  // Line length register; the front end clamps it to the legal range.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes <= LINE_BYTES_RESET;
    end else if (cfg_write) begin
      line_bytes <= cfg_data;
    end
  end

  // The front end tracks the line position and motor phase, so each queued
  // byte already knows whether it opens or closes a line.
  tpls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .line_bytes (line_bytes),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .dot_byte   (dot_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  tpls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back end works on the queue head in place and pops it with the
  // item's final action, so the next byte starts without a bubble.
  tpls_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (action),
    .data_bit     (data_bit),
    .strobe_group (strobe_group),
    .coil_pattern (coil_pattern),
    .last_action  (last_action)
  );

endmodule

// ===== dv/thermal_printhead_line_sequencer_tb.sv =====
// Self-checking testbench for the thermal printhead line sequencer.
// Depends on tpls_pkg and the top level thermal_printhead_line_sequencer; nothing else.
module thermal_printhead_line_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpls_pkg::*;

  // The run is stopped here if the block hangs.
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 28;
  localparam int RANDOM_ITEMS = 350;
  localparam int PRINT_CAP = 25;

  // Coil patterns of the four full-step phases, coils A, A_n, B, B_n.
  localparam logic [3:0] STEP_COILS [4] = '{4'h5, 4'h6, 4'hA, 4'h9};

  // One pin action item as the block should emit it.
  typedef struct packed {
    action_t    act;
    logic       dot;
    logic [1:0] grp;
    logic [3:0] coil;
    logic       last;
  } pin_action_t;

  // One directed row: an optional line length written first, then a byte.
  // A nonzero action count is the burst length read straight off the rules.
  typedef struct {
    bit         set_len;
    logic [6:0] len;
    logic [7:0] dots;
    int         actions;
  } dot_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [6:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] dot_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] action;
  logic       data_bit;
  logic [1:0] strobe_group;
  logic [3:0] coil_pattern;
  logic       last_action;

  // Burst length the current directed row claims; zero means not typed in.
  int row_actions = 0;

  // Shadow of the block: line length register, position in line, motor phase.
  logic [6:0] shadow_line_bytes = LINE_BYTES_RESET;
  logic [5:0] shadow_position = '0;
  logic [1:0] shadow_phase = '0;

  pin_action_t pending_actions[$];

  int errors = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int actions_checked = 0;
  int lines_closed = 0;
  int length_writes = 0;
  bit calm_sender = 1'b0;

  thermal_printhead_line_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .dot_byte     (dot_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (action),
    .data_bit     (data_bit),
    .strobe_group (strobe_group),
    .coil_pattern (coil_pattern),
    .last_action  (last_action)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d actions still due", cycles,
               pending_actions.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Expands one accepted dot byte into the actions it must cause, appends
  // them to pending_actions and advances the shadow state. Returns the count.
  function automatic int expand_dot_byte(input logic [7:0] dots);
    pin_action_t burst[$];
    pin_action_t item;
    int len;
    begin
      // A length of zero acts as one, anything past the maximum as the maximum.
      len = int'(shadow_line_bytes);
      if (len < 1) len = 1;
      if (len > LINE_BYTES_MAX) len = LINE_BYTES_MAX;
      item = '0;
      if (shadow_position == '0) begin
        item.act = ACT_ENABLE;
        burst.push_back(item);
      end
      for (int k = 7; k >= 0; k--) begin
        item = '0;
        item.act = ACT_SHIFT;
        item.dot = dots[k];
        burst.push_back(item);
      end
      // A length lowered below the current position ends the line here too.
      if (int'(shadow_position) + 1 >= len) begin
        item = '0;
        item.act = ACT_LATCH;
        burst.push_back(item);
        for (int g = 0; g < 3; g++) begin
          item = '0;
          item.act = ACT_STROBE;
          item.grp = 2'(g);
          burst.push_back(item);
        end
        for (int s = 0; s < 2; s++) begin
          item = '0;
          item.act = ACT_STEP;
          item.coil = STEP_COILS[shadow_phase];
          burst.push_back(item);
          shadow_phase = shadow_phase + 2'd1;
        end
        item = '0;
        item.act = ACT_DISABLE;
        burst.push_back(item);
        shadow_position = '0;
        lines_closed++;
      end else begin
        shadow_position = shadow_position + 6'd1;
      end
      burst[burst.size() - 1].last = 1'b1;
      foreach (burst[j]) pending_actions.push_back(burst[j]);
      return burst.size();
    end
  endfunction

  // Watches both channels and the register port at every rising edge. The stimulus
  // only looks at pending_actions at falling edges, so there is no race.
  always @(posedge clk) begin
    int n;
    pin_action_t want;
    if (!rst) begin
      if (cfg_write) begin
        shadow_line_bytes = cfg_data;
      end
      if (in_valid && in_ready) begin
        n = expand_dot_byte(dot_byte);
        if (row_actions != 0 && n != row_actions) begin
          report_mismatch($sformatf("byte %02h gives %0d actions, table row says %0d",
                                    dot_byte, n, row_actions));
        end
      end
      if (out_valid && out_ready) begin
        if (pending_actions.size() == 0) begin
          report_mismatch($sformatf("unexpected action %0d with nothing due", action));
        end else begin
          want = pending_actions.pop_front();
          actions_checked++;
          if (action !== want.act || data_bit !== want.dot || strobe_group !== want.grp ||
              coil_pattern !== want.coil || last_action !== want.last) begin
            report_mismatch($sformatf(
              "act %0d/%0d dot %b/%b grp %0d/%0d coil %h/%h last %b/%b (got/want)",
              action, want.act, data_bit, want.dot, strobe_group, want.grp,
              coil_pattern, want.coil, last_action, want.last));
          end
        end
      end
    end
  end

  // The receiver stalls at random, holds off once for a long stretch while
  // the sender keeps offering bytes, and runs a window with no stalls at all.
  initial begin : receiver
    int rx_cycle;
    int hold_left;
    bit held;
    rx_cycle = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!held && rx_cycle >= 1500 && in_valid) begin
        // The two-entry queue fills during this hold and in_ready drops.
        held = 1'b1;
        hold_left = 299;
        out_ready <= 1'b0;
      end else if (rx_cycle >= 2500 && rx_cycle < 3300) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offers one byte, idling first at random, and returns at the edge where
  // it is taken with valid still high, so back-to-back bytes need no drop.
  task automatic send_dot_byte(input logic [7:0] dots, input int typed);
    while (!calm_sender && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    dot_byte <= dots;
    row_actions <= typed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Drops valid, lets every due action drain, pauses for the pipeline and
  // then writes the line length. The first falling edge lets the monitor book
  // the byte taken at the edge just passed.
  task automatic write_line_bytes(input logic [6:0] len);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_actions.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    cfg_write <= 1'b0;
    length_writes++;
  endtask

  initial begin : stimulus
    dot_row_t rows [21];
    int eff;
    int nb;
    int sent_random;
    int pick;
    logic [6:0] len;
    logic [7:0] dots;

    // Directed rows. After reset the line is 48 bytes long; the third row
    // cuts the line to one byte while two bytes are already in, so that byte
    // closes the line without an enable. Zero and 127 test the clamping.
    rows = '{
      '{1'b0, 7'd0,   8'h00, 9},
      '{1'b0, 7'd0,   8'hFF, 8},
      '{1'b1, 7'd1,   8'hA5, 15},
      '{1'b0, 7'd0,   8'h5A, 16},
      '{1'b0, 7'd0,   8'h80, 16},
      '{1'b0, 7'd0,   8'h01, 16},
      '{1'b1, 7'd0,   8'h3C, 16},
      '{1'b0, 7'd0,   8'hC3, 16},
      '{1'b1, 7'd127, 8'h0F, 9},
      '{1'b0, 7'd0,   8'hF0, 8},
      '{1'b1, 7'd2,   8'h66, 15},
      '{1'b0, 7'd0,   8'h55, 9},
      '{1'b0, 7'd0,   8'hAA, 15},
      '{1'b1, 7'd65,  8'h12, 9},
      '{1'b1, 7'd64,  8'h34, 8},
      '{1'b1, 7'd3,   8'h4B, 15},
      '{1'b0, 7'd0,   8'h77, 9},
      '{1'b0, 7'd0,   8'h88, 8},
      '{1'b0, 7'd0,   8'h99, 15},
      '{1'b1, 7'd48,  8'hFE, 0},
      '{1'b0, 7'd0,   8'h7F, 0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].set_len) write_line_bytes(rows[i].len);
      send_dot_byte(rows[i].dots, rows[i].actions);
    end

    // Random phases: pick a length, mostly short, then send a few whole
    // lines and often a partial one, so the next length lands mid-line.
    sent_random = 0;
    while (sent_random < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) len = 7'd0;
      else if (pick < 70) len = 7'($urandom_range(1, 6));
      else if (pick < 88) len = 7'($urandom_range(7, 16));
      else if (pick < 94) len = 7'd64;
      else len = 7'($urandom_range(65, 127));
      eff = (len == 0) ? 1 : ((len > LINE_BYTES_MAX) ? LINE_BYTES_MAX : int'(len));
      if (eff > 16) nb = eff + $urandom_range(0, eff / 4);
      else nb = eff * $urandom_range(1, 4) + $urandom_range(0, eff - 1);
      write_line_bytes(len);
      for (int k = 0; k < nb && sent_random < RANDOM_ITEMS; k++) begin
        calm_sender = (sent_random >= 120 && sent_random < 200);
        pick = $urandom_range(0, 9);
        if (pick == 0) dots = 8'h00;
        else if (pick == 1) dots = 8'hFF;
        else dots = 8'($urandom_range(0, 255));
        send_dot_byte(dots, 0);
        sent_random++;
      end
    end
    calm_sender = 1'b0;

    // Drain, then give the block time to show any stray action.
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_actions.size() != 0) @(negedge clk);
    repeat (30) @(posedge clk);
    if (pending_actions.size() != 0) begin
      report_mismatch($sformatf("%0d actions never arrived", pending_actions.size()));
    end

    $display("Covered %0d dot bytes under %0d line length writes: %0d actions checked,",
             bytes_sent, length_writes, actions_checked);
    $display("%0d lines closed, with a long output hold-off and random stalls.",
             lines_closed);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tpls_pkg.sv
rtl/tpls_front.sv
rtl/tpls_queue.sv
rtl/tpls_back.sv
rtl/thermal_printhead_line_sequencer.sv
dv/thermal_printhead_line_sequencer_tb.sv
